// ===== hdl/drt_pkg.sv =====
// Shared types and constants for the damage region tracker.
// Used by drt_calc and damage_region_tracker_top; depends on nothing.
package drt_pkg;

    typedef enum logic [2:0] {
        CMD_BEGIN = 3'd0,
        CMD_MARK  = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_MOVE  = 3'd3,
        CMD_FLUSH = 3'd4
    } t_cmd;

    localparam logic KIND_REPAINT = 1'b0;
    localparam logic KIND_FLUSH   = 1'b1;

    localparam logic [1:0] CFG_SCREEN_W = 2'd0;
    localparam logic [1:0] CFG_SCREEN_H = 2'd1;

    localparam int SCREEN_BITS = 15;
    localparam logic [SCREEN_BITS-1:0] SCREEN_W_RST = 15'd1024;
    localparam logic [SCREEN_BITS-1:0] SCREEN_H_RST = 15'd768;

    // most results one request can cause
    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [2:0] cnt;
        logic       kind;
    } t_res_ctl;

endpackage

// ===== hdl/drt_calc.sv =====
// Single-pass combinational step of the damage region tracker: repaint strips,
// bounding box update and clipped flush for one request. Depends on drt_pkg.
module drt_calc #(
    parameter int CB = 16
) (
    input  logic [2:0]                        i_cmd,
    input  logic signed [CB-1:0]              i_rect_x,
    input  logic signed [CB-1:0]              i_rect_y,
    input  logic signed [CB-1:0]              i_rect_w,
    input  logic signed [CB-1:0]              i_rect_h,
    input  logic signed [CB-1:0]              i_new_x,
    input  logic signed [CB-1:0]              i_new_y,
    input  logic signed [CB-1:0]              i_new_w,
    input  logic signed [CB-1:0]              i_new_h,
    input  logic signed [CB+1:0]              i_box_l,
    input  logic signed [CB+1:0]              i_box_t,
    input  logic signed [CB+1:0]              i_box_r,
    input  logic signed [CB+1:0]              i_box_b,
    input  logic [drt_pkg::SCREEN_BITS-1:0]   i_screen_w,
    input  logic [drt_pkg::SCREEN_BITS-1:0]   i_screen_h,
    output logic signed [CB+1:0]              o_box_l,
    output logic signed [CB+1:0]              o_box_t,
    output logic signed [CB+1:0]              o_box_r,
    output logic signed [CB+1:0]              o_box_b,
    output drt_pkg::t_res_ctl                 o_ctl,
    output logic signed [CB-1:0]              o_x [drt_pkg::MAX_RES],
    output logic signed [CB-1:0]              o_y [drt_pkg::MAX_RES],
    output logic signed [CB:0]                o_w [drt_pkg::MAX_RES],
    output logic signed [CB:0]                o_h [drt_pkg::MAX_RES]
);

    localparam int BW = CB + 2;
    localparam int FW = (CB + 4 > drt_pkg::SCREEN_BITS + 2) ? CB + 4
                                                            : drt_pkg::SCREEN_BITS + 2;
    localparam int NG = drt_pkg::MAX_RES + 1;

    logic signed [BW-1:0] ox, oy, ow, oh, nx, ny, nw, nh;
    logic signed [BW-1:0] ox1, oy1, nx1, ny1;
    logic signed [BW-1:0] ix0, iy0, ix1, iy1;
    logic                 eq, disj;
    logic signed [BW-1:0] cx [drt_pkg::MAX_RES];
    logic signed [BW-1:0] cy [drt_pkg::MAX_RES];
    logic signed [BW-1:0] cw [drt_pkg::MAX_RES];
    logic signed [BW-1:0] ch [drt_pkg::MAX_RES];
    logic [drt_pkg::MAX_RES-1:0] cv;
    logic signed [BW-1:0] gx [NG];
    logic signed [BW-1:0] gy [NG];
    logic signed [BW-1:0] gw [NG];
    logic signed [BW-1:0] gh [NG];
    logic [NG-1:0]        gv;
    logic signed [FW-1:0] fx, fy, fw, fh, sw, sh;
    logic                 flush_ok;
    logic [2:0]           pos;

    assign ox = BW'(i_rect_x);
    assign oy = BW'(i_rect_y);
    assign ow = BW'(i_rect_w);
    assign oh = BW'(i_rect_h);
    assign nx = BW'(i_new_x);
    assign ny = BW'(i_new_y);
    assign nw = BW'(i_new_w);
    assign nh = BW'(i_new_h);

    assign ox1 = ox + ow;
    assign oy1 = oy + oh;
    assign nx1 = nx + nw;
    assign ny1 = ny + nh;

    // overlap of old and new window
    assign ix0 = (ox > nx) ? ox : nx;
    assign iy0 = (oy > ny) ? oy : ny;
    assign ix1 = (ox1 < nx1) ? ox1 : nx1;
    assign iy1 = (oy1 < ny1) ? oy1 : ny1;

    assign eq   = (i_rect_x == i_new_x) && (i_rect_y == i_new_y) &&
                  (i_rect_w == i_new_w) && (i_rect_h == i_new_h);
    assign disj = (ix0 >= ix1) || (iy0 >= iy1);

    // flush region clipped to the screen
    always_comb begin
        sw = $signed({{(FW-drt_pkg::SCREEN_BITS){1'b0}}, i_screen_w});
        sh = $signed({{(FW-drt_pkg::SCREEN_BITS){1'b0}}, i_screen_h});
        fx = FW'(i_box_l);
        fy = FW'(i_box_t);
        fw = FW'(i_box_r) - FW'(i_box_l);
        fh = FW'(i_box_b) - FW'(i_box_t);
        if (fx < 0) begin
            fw = fw + fx;
            fx = '0;
        end
        if (fy < 0) begin
            fh = fh + fy;
            fy = '0;
        end
        if (fx + fw > sw) begin
            fw = sw - fx;
        end
        if (fy + fh > sh) begin
            fh = sh - fy;
        end
        flush_ok = (fw > 0) && (fh > 0);
    end

    // repaint candidates
    always_comb begin
        for (int i = 0; i < drt_pkg::MAX_RES; i++) begin
            cx[i] = ox;
            cy[i] = oy;
            cw[i] = ow;
            ch[i] = oh;
        end
        cv = '0;
        gx[NG-1] = ox;
        gy[NG-1] = oy;
        gw[NG-1] = ow;
        gh[NG-1] = oh;
        gv[NG-1] = 1'b0;
        case (i_cmd)
            drt_pkg::CMD_MARK: begin
                gv[NG-1] = 1'b1;
            end
            drt_pkg::CMD_CLEAR: begin
                cv[0] = 1'b1;
            end
            drt_pkg::CMD_MOVE: begin
                if (!eq) begin
                    gx[NG-1] = nx;
                    gy[NG-1] = ny;
                    gw[NG-1] = nw;
                    gh[NG-1] = nh;
                    gv[NG-1] = 1'b1;
                    if (disj) begin
                        cv[0] = 1'b1;
                    end else begin
                        // top, bottom, left, right strips outside the overlap
                        ch[0] = iy0 - oy;
                        cv[0] = oy < iy0;
                        cy[1] = iy1;
                        ch[1] = oy1 - iy1;
                        cv[1] = oy1 > iy1;
                        cy[2] = iy0;
                        cw[2] = ix0 - ox;
                        ch[2] = iy1 - iy0;
                        cv[2] = ox < ix0;
                        cx[3] = ix1;
                        cy[3] = iy0;
                        cw[3] = ox1 - ix1;
                        ch[3] = iy1 - iy0;
                        cv[3] = ox1 > ix1;
                    end
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < drt_pkg::MAX_RES; i++) begin
            gx[i] = cx[i];
            gy[i] = cy[i];
            gw[i] = cw[i];
            gh[i] = ch[i];
            gv[i] = cv[i];
        end
    end

    // bounding box update
    always_comb begin
        o_box_l = i_box_l;
        o_box_t = i_box_t;
        o_box_r = i_box_r;
        o_box_b = i_box_b;
        if (i_cmd == drt_pkg::CMD_BEGIN) begin
            o_box_l = {1'b0, {(BW-1){1'b1}}};
            o_box_t = {1'b0, {(BW-1){1'b1}}};
            o_box_r = '1;
            o_box_b = '1;
        end else begin
            for (int i = 0; i < NG; i++) begin
                if (gv[i] && gw[i] > 0 && gh[i] > 0) begin
                    if (gx[i] < o_box_l) o_box_l = gx[i];
                    if (gy[i] < o_box_t) o_box_t = gy[i];
                    if (gx[i] + gw[i] > o_box_r) o_box_r = gx[i] + gw[i];
                    if (gy[i] + gh[i] > o_box_b) o_box_b = gy[i] + gh[i];
                end
            end
        end
    end

    // pack the results that exist into consecutive slots
    always_comb begin
        for (int i = 0; i < drt_pkg::MAX_RES; i++) begin
            o_x[i] = '0;
            o_y[i] = '0;
            o_w[i] = '0;
            o_h[i] = '0;
        end
        pos = '0;
        o_ctl.kind = drt_pkg::KIND_REPAINT;
        if (i_cmd == drt_pkg::CMD_FLUSH) begin
            if (flush_ok) begin
                o_x[0] = fx[CB-1:0];
                o_y[0] = fy[CB-1:0];
                o_w[0] = fw[CB:0];
                o_h[0] = fh[CB:0];
                pos = 3'd1;
            end
            o_ctl.kind = drt_pkg::KIND_FLUSH;
        end else begin
            for (int i = 0; i < drt_pkg::MAX_RES; i++) begin
                if (cv[i]) begin
                    o_x[pos[1:0]] = cx[i][CB-1:0];
                    o_y[pos[1:0]] = cy[i][CB-1:0];
                    o_w[pos[1:0]] = cw[i][CB:0];
                    o_h[pos[1:0]] = ch[i][CB:0];
                    pos = pos + 3'd1;
                end
            end
        end
        o_ctl.cnt = pos;
    end

endmodule

// ===== hdl/damage_region_tracker_top.sv =====
// Damage region tracker top level: request register, result buffer and
// screen size registers around drt_calc. Depends on drt_pkg and drt_calc.
//
//  channel  direction  handshake                       payload
//  s_axis   in         s_axis_tvalid / s_axis_tready   tuser command, tdata rectangles
//  m_axis   out        m_axis_tvalid / m_axis_tready   tuser kind, tdata rect, tlast
//  cfg      in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// A request is evaluated once it is registered and the buffer is free; its results
// (zero to four) then leave one per cycle while m_axis_tready allows, from a four-entry buffer.
// The next request is evaluated in the cycle its predecessor's last result
// is taken, so a move with four strips holds off the next request until all four have left.
// Reset empties the box, restores the 1024 x 768 screen and drops pending work.
// A stalled output holds the buffer; the request register still takes one request.
module damage_region_tracker_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // rect_x, rect_y, rect_w, rect_h, new_x, new_y, new_w, new_h
    input  logic [8*COORD_BITS-1:0]     s_axis_tdata,
    // command
    input  logic [2:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_x, out_y, out_w, out_h, zero fill
    output logic [((4*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata,
    // result_kind
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [drt_pkg::SCREEN_BITS-1:0] i_cfg_data
);

    localparam int CB   = COORD_BITS;
    localparam int BW   = CB + 2;
    localparam int OTDW = ((4 * CB + 2 + 7) / 8) * 8;
    localparam int NRES = drt_pkg::MAX_RES;

    logic                     r_in_valid;
    logic [2:0]               r_cmd;
    logic signed [CB-1:0]     r_fld [8];
    logic signed [BW-1:0]     r_box_l, r_box_t, r_box_r, r_box_b;
    logic signed [BW-1:0]     n_box_l, n_box_t, n_box_r, n_box_b;
    logic [drt_pkg::SCREEN_BITS-1:0] r_screen_w, r_screen_h;
    logic signed [CB-1:0]     r_buf_x [NRES];
    logic signed [CB-1:0]     r_buf_y [NRES];
    logic signed [CB:0]       r_buf_w [NRES];
    logic signed [CB:0]       r_buf_h [NRES];
    logic [2:0]               r_cnt;
    logic [1:0]               r_rd;
    logic                     r_kind;
    drt_pkg::t_res_ctl        n_ctl;
    logic signed [CB-1:0]     n_x [NRES];
    logic signed [CB-1:0]     n_y [NRES];
    logic signed [CB:0]       n_w [NRES];
    logic signed [CB:0]       n_h [NRES];
    logic                     take, last, buf_free, fire;

    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign take          = m_axis_tvalid && m_axis_tready;
    assign last          = ({1'b0, r_rd} == (r_cnt - 3'd1));
    assign buf_free      = (r_cnt == 3'd0) || (take && last);
    assign fire          = r_in_valid && buf_free;
    assign s_axis_tready = !r_in_valid || fire;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tuser = r_kind;
    assign m_axis_tlast = last;
    assign m_axis_tdata = OTDW'({r_buf_h[r_rd], r_buf_w[r_rd], r_buf_y[r_rd], r_buf_x[r_rd]});

    drt_calc #(
        .CB (CB)
    ) u_calc (
        .i_cmd      (r_cmd),
        .i_rect_x   (r_fld[0]),
        .i_rect_y   (r_fld[1]),
        .i_rect_w   (r_fld[2]),
        .i_rect_h   (r_fld[3]),
        .i_new_x    (r_fld[4]),
        .i_new_y    (r_fld[5]),
        .i_new_w    (r_fld[6]),
        .i_new_h    (r_fld[7]),
        .i_box_l    (r_box_l),
        .i_box_t    (r_box_t),
        .i_box_r    (r_box_r),
        .i_box_b    (r_box_b),
        .i_screen_w (r_screen_w),
        .i_screen_h (r_screen_h),
        .o_box_l    (n_box_l),
        .o_box_t    (n_box_t),
        .o_box_r    (n_box_r),
        .o_box_b    (n_box_b),
        .o_ctl      (n_ctl),
        .o_x        (n_x),
        .o_y        (n_y),
        .o_w        (n_w),
        .o_h        (n_h)
    );

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= s_axis_tuser;
            for (int i = 0; i < 8; i++) begin
                r_fld[i] <= s_axis_tdata[i*CB +: CB];
            end
        end
    end

    // box and screen size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_l    <= {1'b0, {(BW-1){1'b1}}};
            r_box_t    <= {1'b0, {(BW-1){1'b1}}};
            r_box_r    <= '1;
            r_box_b    <= '1;
            r_screen_w <= drt_pkg::SCREEN_W_RST;
            r_screen_h <= drt_pkg::SCREEN_H_RST;
        end else begin
            if (fire) begin
                r_box_l <= n_box_l;
                r_box_t <= n_box_t;
                r_box_r <= n_box_r;
                r_box_b <= n_box_b;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    drt_pkg::CFG_SCREEN_W: r_screen_w <= i_cfg_data;
                    drt_pkg::CFG_SCREEN_H: r_screen_h <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (fire) begin
            r_cnt <= n_ctl.cnt;
            r_rd  <= '0;
        end else if (take) begin
            if (last) begin
                r_cnt <= '0;
            end else begin
                r_rd <= r_rd + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_kind <= n_ctl.kind;
            for (int i = 0; i < NRES; i++) begin
                r_buf_x[i] <= n_x[i];
                r_buf_y[i] <= n_y[i];
                r_buf_w[i] <= n_w[i];
                r_buf_h[i] <= n_h[i];
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(NRES))
        else $error("result count out of range");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, r_rd} < r_cnt))
        else $error("read pointer past result count");

    a_mid_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !last) |=> (m_axis_tvalid && $stable(r_cnt)))
        else $error("result batch cut short");

    a_ready_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && s_axis_tready) |-> fire)
        else $error("request accepted over a held request");

    a_begin_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_cmd == drt_pkg::CMD_BEGIN) |=> (r_box_r == '1 && r_box_b == '1))
        else $error("begin did not empty the box");

endmodule
